// ===== rtl/tgfb_pkg.sv =====
// Shared types, constants and the 5x7 glyph table for the text glyph frame store writer.
// Used by the controller, the datapath and the top level; depends on nothing.
package tgfb_pkg;

	localparam int SCREEN_COLUMNS = 128;
	localparam int SCREEN_PAGES   = 8;
	localparam int GLYPH_WIDTH    = 5;
	localparam int CELL_WIDTH     = 6;
	localparam int GLYPH_COUNT    = 59;
	localparam int GLYPH_IDX_W    = 6;
	// page (3 bits) times up to 256 columns plus an 8-bit column
	localparam int WIDE_ADDR_W    = 13;

	typedef enum logic [1:0] {
		ACT_DRAW  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DRAW,
		ST_CLEAR,
		ST_READ,
		ST_READ_DATA
	} state_t;

	typedef struct packed {
		logic load;
		logic cnt_clr;
		logic cnt_inc;
		logic wr_draw;
		logic wr_sweep;
		logic rd_en;
		logic respond;
		logic resp_flag;
		logic resp_rdata;
	} dp_cmd_t;

	typedef struct packed {
		action_t act;
		logic    draw_ok;
		logic    read_ok;
		logic    draw_last;
		logic    sweep_last;
	} dp_stat_t;

	// one entry per glyph, column 0 in the low byte
	localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
		40'h0041221C00, 40'h001C224100, 40'h082A1C2A08, 40'h08083E0808,
		40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
		40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
		40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
		40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
		40'h4122140800, 40'h1414141414, 40'h0008142241, 40'h0609510102,
		40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
		40'h1C2241417F, 40'h414949497F, 40'h010109097F, 40'h325141413E,
		40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
		40'h404040407F, 40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E,
		40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2020201F, 40'h3F4038403F,
		40'h6314081463, 40'h0304780403, 40'h4345495161
	};

	// map a character code to its glyph; lowercase folds onto uppercase
	function automatic logic [GLYPH_IDX_W-1:0] glyph_select(input logic [7:0] code);
		logic [GLYPH_IDX_W-1:0] idx;
		idx = '0;
		if (code >= 8'd33 && code <= 8'd90)
			idx = GLYPH_IDX_W'(code - 8'd32);
		else if (code >= 8'd97 && code <= 8'd122)
			idx = GLYPH_IDX_W'(code - 8'd64);
		return idx;
	endfunction

	// one glyph column; the spacing column and unused indexes are blank
	function automatic logic [7:0] glyph_column(input logic [GLYPH_IDX_W-1:0] idx,
	                                             input logic [2:0] k);
		logic [39:0] entry;
		logic [7:0]  col;
		entry = '0;
		if (int'(idx) < GLYPH_COUNT)
			entry = GLYPH_ROM[idx];
		case (k)
			3'd0: col = entry[7:0];
			3'd1: col = entry[15:8];
			3'd2: col = entry[23:16];
			3'd3: col = entry[31:24];
			3'd4: col = entry[39:32];
			default: col = 8'h00;
		endcase
		return col;
	endfunction

endpackage

// ===== rtl/tgfb_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tgfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tgfb_ctrl.sv =====
// Controller state machine: reset sweep, draw, clear and read sequencing.
// Depends on tgfb_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module tgfb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tgfb_pkg::dp_stat_t stat,
	output tgfb_pkg::dp_cmd_t  cmd,
	output logic              busy
);

	tgfb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tgfb_pkg::ST_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			tgfb_pkg::ST_INIT, tgfb_pkg::ST_CLEAR: begin
				cmd.wr_sweep = 1'b1;
				if (stat.sweep_last) begin
					// only a requested clear reports back
					cmd.respond = (state_q == tgfb_pkg::ST_CLEAR);
					state_d     = tgfb_pkg::ST_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			tgfb_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load    = 1'b1;
					cmd.cnt_clr = 1'b1;
					case (stat.act)
						tgfb_pkg::ACT_DRAW: begin
							if (stat.draw_ok) begin
								state_d = tgfb_pkg::ST_DRAW;
							end else begin
								cmd.respond   = 1'b1;
								cmd.resp_flag = 1'b1;
							end
						end
						tgfb_pkg::ACT_CLEAR: begin
							state_d = tgfb_pkg::ST_CLEAR;
						end
						tgfb_pkg::ACT_READ: begin
							if (stat.read_ok) begin
								state_d = tgfb_pkg::ST_READ;
							end else begin
								cmd.respond   = 1'b1;
								cmd.resp_flag = 1'b1;
							end
						end
						default: begin
							cmd.respond = 1'b1;
						end
					endcase
				end
			end
			tgfb_pkg::ST_DRAW: begin
				cmd.wr_draw = 1'b1;
				if (stat.draw_last) begin
					cmd.respond = 1'b1;
					state_d     = tgfb_pkg::ST_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			tgfb_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = tgfb_pkg::ST_READ_DATA;
			end
			tgfb_pkg::ST_READ_DATA: begin
				cmd.respond    = 1'b1;
				cmd.resp_rdata = 1'b1;
				state_d        = tgfb_pkg::ST_IDLE;
			end
			default: begin
				state_d = tgfb_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != tgfb_pkg::ST_IDLE);

	a_draw_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tgfb_pkg::ST_DRAW && stat.draw_last) |=> (state_q == tgfb_pkg::ST_IDLE))
		else $error("draw did not return to idle after last column");

	a_read_two_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tgfb_pkg::ST_READ) |=> (state_q == tgfb_pkg::ST_READ_DATA && cmd.respond))
		else $error("read request not answered after RAM latency");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.wr_draw, cmd.wr_sweep, cmd.rd_en}) <= 1)
		else $error("more than one RAM access issued at once");

endmodule

// ===== rtl/tgfb_dp.sv =====
// Datapath: request decode, address and glyph column generation, frame store RAM
// and result registers. Depends on tgfb_pkg and tgfb_ram.
module tgfb_dp #(
	parameter int SCREEN_COLUMNS = tgfb_pkg::SCREEN_COLUMNS,
	parameter int SCREEN_PAGES   = tgfb_pkg::SCREEN_PAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         action,
	input  logic [7:0]         column,
	input  logic [2:0]         page,
	input  logic [7:0]         char_code,
	input  tgfb_pkg::dp_cmd_t  cmd,
	output tgfb_pkg::dp_stat_t stat,
	output logic               done,
	output logic [7:0]         read_data,
	output logic               status
);

	localparam int DEPTH  = SCREEN_COLUMNS * SCREEN_PAGES;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [ADDR_W-1:0]                addr_q;
	logic [tgfb_pkg::GLYPH_IDX_W-1:0] glyph_q;
	logic [ADDR_W-1:0]                cnt_q;
	logic                             done_q;
	logic                             status_q;
	logic [7:0]                       read_data_q;

	logic [tgfb_pkg::WIDE_ADDR_W-1:0] wide_addr;
	logic                             page_ok;
	logic [ADDR_W-1:0]                wr_addr;
	logic [7:0]                       wr_data;
	logic                             wr_en;
	logic [7:0]                       ram_rdata;

	assign page_ok   = (5'(page) < 5'(SCREEN_PAGES));
	assign wide_addr = tgfb_pkg::WIDE_ADDR_W'(page) * tgfb_pkg::WIDE_ADDR_W'(SCREEN_COLUMNS)
	                 + tgfb_pkg::WIDE_ADDR_W'(column);

	always_comb begin
		stat.act        = tgfb_pkg::action_t'(action);
		stat.draw_ok    = page_ok &&
		                  (10'(column) + 10'(tgfb_pkg::CELL_WIDTH) <= 10'(SCREEN_COLUMNS));
		stat.read_ok    = page_ok && (9'(column) < 9'(SCREEN_COLUMNS));
		stat.draw_last  = (cnt_q == ADDR_W'(tgfb_pkg::CELL_WIDTH - 1));
		stat.sweep_last = (cnt_q == ADDR_W'(DEPTH - 1));
	end

	// hold the request position and glyph for the whole action
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q  <= wide_addr[ADDR_W-1:0];
			glyph_q <= tgfb_pkg::glyph_select(char_code);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.cnt_clr)
			cnt_q <= '0;
		else if (cmd.cnt_inc)
			cnt_q <= cnt_q + ADDR_W'(1);
	end

	assign wr_en   = cmd.wr_draw | cmd.wr_sweep;
	assign wr_addr = cmd.wr_sweep ? cnt_q : addr_q + cnt_q;
	assign wr_data = cmd.wr_draw ? tgfb_pkg::glyph_column(glyph_q, cnt_q[2:0]) : 8'h00;

	tgfb_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (cmd.rd_en),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.respond;
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			status_q    <= cmd.resp_flag;
			read_data_q <= cmd.resp_rdata ? ram_rdata : 8'h00;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign read_data = read_data_q;

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((ADDR_W+1)'(wr_addr) < (ADDR_W+1)'(DEPTH)))
		else $error("frame store write beyond the store");

	a_skip_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q) |-> (read_data_q == 8'h00))
		else $error("skipped request returned data");

	a_draw_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_draw |-> (cnt_q < ADDR_W'(tgfb_pkg::CELL_WIDTH)))
		else $error("draw wrote past the character cell");

endmodule

// ===== rtl/text_glyph_framebuffer_writer_unit.sv =====
// Top level of the text glyph frame store writer.
// Depends on tgfb_pkg, tgfb_ctrl and tgfb_dp.

// A request is taken at a clock edge with start high and busy low; its single result
// appears on read_data and status for exactly one cycle with done high, and the
// receiver cannot stall it. Results come back in request order. Timing is set by the
// single write port of the frame store: after reset busy stays high while the store is
// swept to zero. A draw writes its six columns one per cycle; done rises as busy falls,
// so the next request can be taken while done is high. A clear sweeps the whole store
// before done. A read issues the registered RAM read, then captures its data into
// read_data. A skipped draw or read, and the unused action code, answer on the next
// cycle.
module text_glyph_framebuffer_writer_unit #(
	parameter int SCREEN_COLUMNS = tgfb_pkg::SCREEN_COLUMNS,
	parameter int SCREEN_PAGES   = tgfb_pkg::SCREEN_PAGES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [7:0] column,
	input  logic [2:0] page,
	input  logic [7:0] char_code,
	output logic       done,
	output logic [7:0] read_data,
	output logic       status
);

	tgfb_pkg::dp_cmd_t  cmd;
	tgfb_pkg::dp_stat_t stat;

	tgfb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	tgfb_dp #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_PAGES  (SCREEN_PAGES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.action   (action),
		.column   (column),
		.page     (page),
		.char_code(char_code),
		.cmd      (cmd),
		.stat     (stat),
		.done     (done),
		.read_data(read_data),
		.status   (status)
	);

endmodule

// ===== dv/text_glyph_framebuffer_writer_unit_tb.sv =====
// Testbench for text_glyph_framebuffer_writer_unit: draw, clear and read requests
// checked against a shadow frame store and glyph table. Depends on tgfb_pkg and the RTL.
module text_glyph_framebuffer_writer_unit_tb;
	import tgfb_pkg::*;

	localparam int STORE_BYTES = SCREEN_COLUMNS * SCREEN_PAGES;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		action_t    act;
		logic [7:0] col;
		logic [2:0] pg;
		logic [7:0] code;
		logic       hold;
	} glyph_cmd_t;

	typedef struct packed {
		action_t    act;
		logic [7:0] col;
		logic [2:0] pg;
		logic [7:0] data;
		logic       flag;
	} glyph_reply_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] action = ACT_NONE;
	logic [7:0] column = 8'h00;
	logic [2:0] page = 3'd0;
	logic [7:0] char_code = 8'h00;
	logic       busy;
	logic       done;
	logic [7:0] read_data;
	logic       status;

	glyph_cmd_t   cmd_q[$];
	glyph_reply_t reply_q[$];
	glyph_cmd_t   cur_cmd;
	logic [7:0]   shadow_fb [STORE_BYTES];

	int err_count = 0;
	int n_results = 0;
	int n_cycles = 0;
	int inflight = 0;
	int burst_left = 1;
	int gap_left = 0;
	int n_draw = 0, n_draw_skip = 0, n_read = 0, n_read_skip = 0, n_clear = 0, n_idle = 0;

	text_glyph_framebuffer_writer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.column    (column),
		.page      (page),
		.char_code (char_code),
		.done      (done),
		.read_data (read_data),
		.status    (status)
	);

	always #1 clk = ~clk;

	// five columns, leftmost in the top byte
	function automatic logic [39:0] glyph_bits(int unsigned g);
		case (g)
			0:  return 40'h0000000000;
			1:  return 40'h00005F0000;
			2:  return 40'h0007000700;
			3:  return 40'h147F147F14;
			4:  return 40'h242A7F2A12;
			5:  return 40'h2313086462;
			6:  return 40'h3649552250;
			7:  return 40'h0005030000;
			8:  return 40'h001C224100;
			9:  return 40'h0041221C00;
			10: return 40'h082A1C2A08;
			11: return 40'h08083E0808;
			12: return 40'h0050300000;
			13: return 40'h0808080808;
			14: return 40'h0060600000;
			15: return 40'h2010080402;
			16: return 40'h3E5149453E;
			17: return 40'h00427F4000;
			18: return 40'h4261514946;
			19: return 40'h2141454B31;
			20: return 40'h1814127F10;
			21: return 40'h2745454539;
			22: return 40'h3C4A494930;
			23: return 40'h0171090503;
			24: return 40'h3649494936;
			25: return 40'h064949291E;
			26: return 40'h0036360000;
			27: return 40'h0056360000;
			28: return 40'h0008142241;
			29: return 40'h1414141414;
			30: return 40'h4122140800;
			31: return 40'h0201510906;
			32: return 40'h324979413E;
			33: return 40'h7E1111117E;
			34: return 40'h7F49494936;
			35: return 40'h3E41414122;
			36: return 40'h7F4141221C;
			37: return 40'h7F49494941;
			38: return 40'h7F09090101;
			39: return 40'h3E41415132;
			40: return 40'h7F0808087F;
			41: return 40'h00417F4100;
			42: return 40'h2040413F01;
			43: return 40'h7F08142241;
			44: return 40'h7F40404040;
			45: return 40'h7F0204027F;
			46: return 40'h7F0408107F;
			47: return 40'h3E4141413E;
			48: return 40'h7F09090906;
			49: return 40'h3E4151215E;
			50: return 40'h7F09192946;
			51: return 40'h4649494931;
			52: return 40'h01017F0101;
			53: return 40'h3F4040403F;
			54: return 40'h1F2020201F;
			55: return 40'h3F4038403F;
			56: return 40'h6314081463;
			57: return 40'h0304780403;
			58: return 40'h6151494543;
			default: return 40'h0000000000;
		endcase
	endfunction

	// fold lowercase onto uppercase; anything unprintable is blank
	function automatic int unsigned glyph_index(logic [7:0] code);
		if (code >= 8'd33 && code <= 8'd90)
			return int'(code) - 32;
		if (code >= 8'd97 && code <= 8'd122)
			return int'(code) - 64;
		return 0;
	endfunction

	// apply one request to the shadow store and return the reply it must give
	function automatic glyph_reply_t render_cmd(glyph_cmd_t c);
		glyph_reply_t r;
		logic [39:0] bits;
		int base;
		r.act = c.act;
		r.col = c.col;
		r.pg = c.pg;
		r.data = 8'h00;
		r.flag = 1'b0;
		case (c.act)
			ACT_DRAW: begin
				n_draw++;
				if (int'(c.col) + CELL_WIDTH > SCREEN_COLUMNS || int'(c.pg) >= SCREEN_PAGES) begin
					r.flag = 1'b1;
					n_draw_skip++;
				end else begin
					bits = glyph_bits(glyph_index(c.code));
					base = int'(c.pg) * SCREEN_COLUMNS + int'(c.col);
					for (int k = 0; k < GLYPH_WIDTH; k++)
						shadow_fb[base + k] = bits[39 - 8 * k -: 8];
					shadow_fb[base + GLYPH_WIDTH] = 8'h00;
				end
			end
			ACT_CLEAR: begin
				n_clear++;
				for (int a = 0; a < STORE_BYTES; a++)
					shadow_fb[a] = 8'h00;
			end
			ACT_READ: begin
				n_read++;
				if (int'(c.col) >= SCREEN_COLUMNS || int'(c.pg) >= SCREEN_PAGES) begin
					r.flag = 1'b1;
					n_read_skip++;
				end else begin
					r.data = shadow_fb[int'(c.pg) * SCREEN_COLUMNS + int'(c.col)];
				end
			end
			default: n_idle++;
		endcase
		return r;
	endfunction

	function automatic void add_cmd(action_t a, int col, int pg, int code, bit hold = 1'b0);
		glyph_cmd_t c;
		c.act = a;
		c.col = col[7:0];
		c.pg = pg[2:0];
		c.code = code[7:0];
		c.hold = hold;
		cmd_q.push_back(c);
	endfunction

	task automatic note_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	// driver: bursts of requests separated by random gaps
	always @(posedge clk) begin
		bit launch;
		launch = 1'b0;
		if (arst_n) begin
			if (done)
				inflight--;
			if (start && !busy) begin
				reply_q.push_back(render_cmd(cur_cmd));
				inflight++;
			end
			if (!(start && busy)) begin
				if (gap_left > 0)
					gap_left--;
				else if (cmd_q.size() > 0 && (!cmd_q[0].hold || inflight == 0))
					launch = 1'b1;
				if (launch) begin
					cur_cmd = cmd_q.pop_front();
					action <= cur_cmd.act;
					column <= cur_cmd.col;
					page <= cur_cmd.pg;
					char_code <= cur_cmd.code;
					start <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else if ($urandom_range(3) == 0) begin
						// long stretch with no idling
						burst_left = $urandom_range(60, 20);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(12, 1);
						gap_left = $urandom_range(8);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: each done strobe retires the oldest outstanding reply
	always @(posedge clk) begin
		glyph_reply_t e;
		if (arst_n && done) begin
			n_results++;
			if (reply_q.size() == 0) begin
				note_mismatch($sformatf("unexpected result data=%02h status=%0b",
					read_data, status));
			end else begin
				e = reply_q.pop_front();
				if (read_data !== e.data)
					note_mismatch($sformatf("%s col=%0d page=%0d: read_data %02h, want %02h",
						e.act.name(), e.col, e.pg, read_data, e.data));
				if (status !== e.flag)
					note_mismatch($sformatf("%s col=%0d page=%0d: status %0b, want %0b",
						e.act.name(), e.col, e.pg, status, e.flag));
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d replies outstanding", n_cycles, reply_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int hist_col[$];
		int hist_pg[$];
		int i, k, n, sel, idx, wc, wp, col, code;
		bit hold;

		for (int a = 0; a < STORE_BYTES; a++)
			shadow_fb[a] = 8'h00;

		// directed: store after reset, edges, blank codes, skips, clear
		add_cmd(ACT_READ, 0, 0, 0);
		add_cmd(ACT_DRAW, 0, 0, "!");
		add_cmd(ACT_READ, 2, 0, 255);
		add_cmd(ACT_READ, 5, 0, 0);
		add_cmd(ACT_DRAW, 122, 7, "z");
		add_cmd(ACT_READ, 122, 7, 0);
		add_cmd(ACT_READ, 127, 7, 0);
		add_cmd(ACT_DRAW, 123, 3, "A");
		add_cmd(ACT_DRAW, 255, 7, 255);
		add_cmd(ACT_DRAW, 10, 2, "Z");
		add_cmd(ACT_READ, 12, 2, 0);
		add_cmd(ACT_DRAW, 10, 2, 255);
		add_cmd(ACT_READ, 12, 2, 0);
		add_cmd(ACT_DRAW, 20, 1, " ");
		add_cmd(ACT_DRAW, 30, 1, "~");
		add_cmd(ACT_DRAW, 40, 4, "[");
		add_cmd(ACT_DRAW, 50, 4, "a");
		add_cmd(ACT_READ, 52, 4, 0);
		add_cmd(ACT_READ, 128, 0, 0);
		add_cmd(ACT_READ, 255, 7, 255);
		add_cmd(ACT_NONE, 255, 7, 255);
		add_cmd(ACT_CLEAR, 0, 0, 0);
		add_cmd(ACT_READ, 0, 0, 0, 1'b1);
		add_cmd(ACT_READ, 124, 7, 0);

		i = 0;
		while (i < 550) begin
			sel = $urandom_range(99);
			hold = (i % 97 == 96);
			if (sel < 45) begin
				col = ($urandom_range(9) == 0) ? $urandom_range(255, 123) : $urandom_range(122);
				wp = $urandom_range(7);
				code = ($urandom_range(9) < 7) ? $urandom_range(126, 32) : $urandom_range(255);
				add_cmd(ACT_DRAW, col, wp, code, hold);
				if (col <= 122) begin
					hist_col.push_back(col);
					hist_pg.push_back(wp);
				end
				i++;
			end else if (sel < 85) begin
				if (hist_col.size() > 0 && $urandom_range(9) < 7) begin
					idx = $urandom_range(hist_col.size() - 1);
					add_cmd(ACT_READ, hist_col[idx] + $urandom_range(5), hist_pg[idx],
						$urandom_range(255), hold);
				end else begin
					add_cmd(ACT_READ, $urandom_range(255), $urandom_range(7),
						$urandom_range(255), hold);
				end
				i++;
			end else if (sel < 88) begin
				add_cmd(ACT_CLEAR, $urandom_range(255), $urandom_range(7), $urandom_range(255), hold);
				i++;
			end else if (sel < 92) begin
				add_cmd(ACT_NONE, $urandom_range(255), $urandom_range(7), $urandom_range(255), hold);
				i++;
			end else begin
				// a word of adjacent cells, then read parts of it back
				n = $urandom_range(5, 2);
				wc = $urandom_range(122 - 6 * (n - 1));
				wp = $urandom_range(7);
				for (k = 0; k < n; k++) begin
					code = $urandom_range(1) ? $urandom_range(90, 65) : $urandom_range(122, 97);
					add_cmd(ACT_DRAW, wc + 6 * k, wp, code);
					hist_col.push_back(wc + 6 * k);
					hist_pg.push_back(wp);
				end
				for (k = 0; k < 3; k++)
					add_cmd(ACT_READ, wc + $urandom_range(6 * n - 1), wp, $urandom_range(255));
				i += n + 3;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start || reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d draws (%0d off the right edge), %0d reads (%0d outside the store)",
			n_draw, n_draw_skip, n_read, n_read_skip);
		$display("plus %0d clears and %0d unused action codes; %0d results checked",
			n_clear, n_idle, n_results);
		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
